### rtl/lkhc_pkg.sv
package lkhc_pkg;

  // default number of entries
  localparam int unsigned DefaultCapacity = 6;

  // fixed field widths
  localparam int unsigned TagW    = 64;
  localparam int unsigned HandleW = 16;
  localparam int unsigned OccW    = 3;

  // request mode codes
  localparam logic ModeLookup = 1'b0;
  localparam logic ModeFlush  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    StHit        = 2'd0,
    StInserted   = 2'd1,
    StCreateFail = 2'd2,
    StFlushed    = 2'd3
  } status_e;

  // input request
  typedef struct packed {
    logic               mode;
    logic [TagW-1:0]    key_tag;
    logic               create_ok;
    logic [HandleW-1:0] new_handle;
  } req_t;

  // output result
  typedef struct packed {
    logic [1:0]         status;
    logic [HandleW-1:0] handle;
    logic               evict_valid;
    logic [HandleW-1:0] evict_handle;
    logic [OccW-1:0]    occupancy;
  } rsp_t;

  // controller states
  typedef enum logic [1:0] {
    CtlIdle,
    CtlSearch,
    CtlUpdate,
    CtlDone
  } ctl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic search;
    logic update;
  } cmd_t;

endpackage

### rtl/lru_keyed_handle_cache_unit.sv
// channel  | signals          | handshake
// ---------+------------------+------------------------------------------
// request  | req_i (req_t)    | taken at a clock edge with start and !busy
// result   | rsp_o (rsp_t)    | valid for one cycle while done_o is high
//
// a request runs through capture into the search stage, the parallel
// tag compare and slot pick, then the entry update with the handle
// store read; the result shows in the done state that follows.
// a new request can be taken in the cycle the result is shown, but
// not while busy is high during the search and update steps.
// reset clears all valid bits, recency ranks and the occupancy count.
// the receiver cannot stall; each result is taken when done_o is high.
module lru_keyed_handle_cache_unit
  import lkhc_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t cmd;

  // sequencer
  lkhc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // entry store and search
  lkhc_dpath #(
    .Capacity (Capacity)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

### rtl/lkhc_ctrl.sv
module lkhc_ctrl
  import lkhc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    busy        = 1'b0;
    done_o      = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      CtlIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = CtlSearch;
        end
      end
      CtlSearch: begin
        busy         = 1'b1;
        cmd_o.search = 1'b1;
        state_d      = CtlUpdate;
      end
      CtlUpdate: begin
        busy         = 1'b1;
        cmd_o.update = 1'b1;
        state_d      = CtlDone;
      end
      CtlDone: begin
        done_o = 1'b1;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = CtlSearch;
        end else begin
          state_d = CtlIdle;
        end
      end
      default: state_d = CtlIdle;
    endcase
  end

  // an accepted request passes through search and update, then raises done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("request did not complete in three cycles");

  // result strobe is a single cycle pulse per request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held more than one cycle");

  // update always follows search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.search |=> cmd_o.update)
    else $error("search not followed by update");

endmodule

### rtl/lkhc_dpath.sv
module lkhc_dpath
  import lkhc_pkg::*;
#(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  localparam int unsigned SlotW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  // captured request
  req_t req_q;

  // entry state
  logic [Capacity-1:0]  valid_q;
  logic [SlotW-1:0]     rank_q [Capacity];
  logic [TagW-1:0]      tag_q  [Capacity];
  logic [HandleW-1:0]   handle_mem [Capacity];
  logic [CntW-1:0]      occ_q;

  // search results
  logic                 hit_q, full_q;
  logic [SlotW-1:0]     slot_q;

  // result registers
  status_e              status_q;
  logic                 evict_q;
  logic [HandleW-1:0]   rd_handle_q;

  // search logic
  logic [Capacity-1:0]  hit_vec;
  logic                 hit;
  logic [SlotW-1:0]     hit_slot, lru_slot, free_slot;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // parallel tag compare and slot pick, lowest index wins
  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    lru_slot  = '0;
    free_slot = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (tag_q[i] == req_q.key_tag);
      if (hit_vec[i]) begin
        hit      = 1'b1;
        hit_slot = SlotW'(i);
      end
      if (rank_q[i] == '0) begin
        lru_slot = SlotW'(i);
      end
      if (!valid_q[i]) begin
        free_slot = SlotW'(i);
      end
    end
  end

  // search result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      hit_q  <= hit;
      full_q <= (occ_q >= CapCnt);
      if (hit) begin
        slot_q <= hit_slot;
      end else if (occ_q >= CapCnt) begin
        slot_q <= lru_slot;
      end else begin
        slot_q <= free_slot;
      end
    end
  end

  // decode of the update step
  logic              do_flush, do_hit, do_insert;
  logic [SlotW-1:0]  slot_rank;
  logic [SlotW-1:0]  age_ref;
  logic              do_age;

  assign do_flush  = (req_q.mode == ModeFlush);
  assign do_hit    = !do_flush && hit_q;
  assign do_insert = !do_flush && !hit_q && req_q.create_ok;
  assign slot_rank = rank_q[slot_q];
  // a hit ages entries above its rank, an eviction ages all above zero
  assign do_age    = do_hit || (do_insert && full_q);
  assign age_ref   = do_hit ? slot_rank : '0;

  // valid bits, ranks and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < Capacity; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      if (do_flush) begin
        valid_q <= '0;
        occ_q   <= '0;
        for (int i = 0; i < Capacity; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        if (do_age) begin
          for (int i = 0; i < Capacity; i++) begin
            if (valid_q[i] && (rank_q[i] > age_ref)) begin
              rank_q[i] <= rank_q[i] - 1'b1;
            end
          end
        end
        if (do_hit) begin
          rank_q[slot_q] <= SlotW'(occ_q - 1'b1);
        end else if (do_insert) begin
          valid_q[slot_q] <= 1'b1;
          if (full_q) begin
            rank_q[slot_q] <= SlotW'(CapCnt - 1'b1);
          end else begin
            rank_q[slot_q] <= SlotW'(occ_q);
            occ_q          <= occ_q + 1'b1;
          end
        end
      end
    end
  end

  // tag and handle storage, handle read before write
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rd_handle_q <= handle_mem[slot_q];
      if (do_insert) begin
        tag_q[slot_q]      <= req_q.key_tag;
        handle_mem[slot_q] <= req_q.new_handle;
      end
    end
  end

  // result status
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      evict_q <= do_insert && full_q;
      priority if (do_flush) begin
        status_q <= StFlushed;
      end else if (do_hit) begin
        status_q <= StHit;
      end else if (do_insert) begin
        status_q <= StInserted;
      end else begin
        status_q <= StCreateFail;
      end
    end
  end

  // result assembly
  always_comb begin
    rsp_o              = '0;
    rsp_o.status       = status_q;
    rsp_o.evict_valid  = evict_q;
    rsp_o.evict_handle = evict_q ? rd_handle_q : '0;
    rsp_o.occupancy    = OccW'(occ_q);
    unique case (status_q)
      StHit:      rsp_o.handle = rd_handle_q;
      StInserted: rsp_o.handle = req_q.new_handle;
      default:    rsp_o.handle = '0;
    endcase
  end

  // occupancy counter tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(occ_q))
    else $error("occupancy differs from valid entry count");

  // store never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CapCnt)
    else $error("occupancy above capacity");

  // eviction happens only on a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && do_insert && full_q) |-> (occ_q == CapCnt))
    else $error("eviction on a store that is not full");

endmodule

### test/lru_keyed_handle_cache_unit_tb.sv
`timescale 1ns / 100ps

module lru_keyed_handle_cache_unit_tb;
  import lkhc_pkg::*;

  localparam int unsigned Slots     = DefaultCapacity;
  localparam int unsigned StallLimit = 2000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  // shadow copy of the cache contents
  bit                 line_valid [Slots];
  logic [TagW-1:0]    line_tag   [Slots];
  logic [HandleW-1:0] line_handle[Slots];
  logic [OccW-1:0]    line_rank  [Slots];

  rsp_t lookup_q[$];
  int   err_cnt;
  int   mism_cnt;
  int   quiet_cycles;
  int   calm_left;

  lru_keyed_handle_cache_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // number of live lines
  function automatic int live_lines();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) if (line_valid[i]) n++;
    return n;
  endfunction

  // every live line more recent than rank r drops one place
  function automatic void demote_above(logic [OccW-1:0] r);
    for (int i = 0; i < Slots; i++)
      if (line_valid[i] && line_rank[i] > r) line_rank[i] = line_rank[i] - 1'b1;
  endfunction

  // expected result of one request, updating the shadow cache
  function automatic rsp_t cache_predict(req_t rq);
    rsp_t rs;
    int   occ;
    int   slot;
    bit   hit;
    rs   = '0;
    slot = 0;
    hit  = 1'b0;
    if (rq.mode == ModeFlush) begin
      for (int i = 0; i < Slots; i++) begin
        line_valid[i] = 1'b0;
        line_rank[i]  = '0;
      end
      rs.status = StFlushed;
    end else begin
      occ = live_lines();
      // lowest matching live line wins
      for (int i = 0; i < Slots; i++) begin
        if (!hit && line_valid[i] && line_tag[i] == rq.key_tag) begin
          slot = i;
          hit  = 1'b1;
        end
      end
      if (hit) begin
        demote_above(line_rank[slot]);
        line_rank[slot] = OccW'(occ - 1);
        rs.handle       = line_handle[slot];
        rs.status       = StHit;
      end else if (!rq.create_ok) begin
        rs.status = StCreateFail;
      end else begin
        if (occ >= Slots) begin
          // full: drop the least recent line first
          for (int i = Slots - 1; i >= 0; i--) if (line_rank[i] == '0) slot = i;
          rs.evict_valid  = 1'b1;
          rs.evict_handle = line_handle[slot];
          line_valid[slot] = 1'b0;
          demote_above('0);
          occ = Slots - 1;
        end else begin
          for (int i = Slots - 1; i >= 0; i--) if (!line_valid[i]) slot = i;
        end
        line_valid[slot]  = 1'b1;
        line_tag[slot]    = rq.key_tag;
        line_handle[slot] = rq.new_handle;
        line_rank[slot]   = OccW'(occ);
        rs.handle         = rq.new_handle;
        rs.status         = StInserted;
      end
    end
    rs.occupancy = OccW'(live_lines());
    return rs;
  endfunction

  // compare results against predictions, then record any request taken
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (lookup_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result %p", rsp_o);
        end else begin
          want = lookup_q.pop_front();
          if (rsp_o.status !== want.status || rsp_o.handle !== want.handle ||
              rsp_o.evict_valid !== want.evict_valid ||
              rsp_o.evict_handle !== want.evict_handle ||
              rsp_o.occupancy !== want.occupancy) begin
            err_cnt++;
            mism_cnt++;
            if (mism_cnt <= 10)
              $display({"mismatch: exp st=%0d h=%h ev=%b eh=%h occ=%0d, ",
                        "got st=%0d h=%h ev=%b eh=%h occ=%0d"},
                       want.status, want.handle, want.evict_valid, want.evict_handle,
                       want.occupancy, rsp_o.status, rsp_o.handle, rsp_o.evict_valid,
                       rsp_o.evict_handle, rsp_o.occupancy);
          end
        end
      end
      if (start && !busy) lookup_q.push_back(cache_predict(req_i));
    end
  end

  // watchdog on cycles with no request or result accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // gap length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one request and wait until the block takes it
  task automatic send_req(input logic m, input logic [TagW-1:0] k, input logic c,
                          input logic [HandleW-1:0] h);
    req_t        r;
    int          gap;
    logic [95:0] noise;
    r.mode       = m;
    r.key_tag    = k;
    r.create_ok  = c;
    r.new_handle = h;
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      noise = {$urandom, $urandom, $urandom};
      start <= 1'b0;
      req_i <= noise[$bits(req_t)-1:0];
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [TagW-1:0] rand_tag();
    return {$urandom, $urandom};
  endfunction

  // extremes, fill to capacity, eviction order, create failure, flush
  task automatic test_directed();
    send_req(ModeFlush, '1, 1'b1, '1);
    send_req(ModeLookup, '0, 1'b0, 16'h1234);
    send_req(ModeLookup, '0, 1'b1, 16'h0000);
    send_req(ModeLookup, '1, 1'b1, 16'hffff);
    send_req(ModeLookup, '0, 1'b1, 16'h5555);
    for (int i = 1; i <= 4; i++)
      send_req(ModeLookup, TagW'(i), 1'b1, HandleW'(16'h1000 + i));
    send_req(ModeLookup, TagW'(5), 1'b1, 16'h2005);
    send_req(ModeLookup, TagW'(1), 1'b1, 16'h0bad);
    send_req(ModeLookup, TagW'(7), 1'b0, 16'h0bad);
    send_req(ModeLookup, TagW'(8), 1'b1, 16'h2008);
    send_req(ModeLookup, '0, 1'b0, 16'h0000);
    send_req(ModeLookup, TagW'(2), 1'b1, 16'h2009);
    send_req(ModeFlush, rand_tag(), 1'b0, HandleW'($urandom));
    send_req(ModeLookup, '0, 1'b0, 16'h0000);
    send_req(ModeLookup, '0, 1'b1, 16'ha5a5);
    send_req(ModeLookup, '0, 1'b0, 16'h5a5a);
    send_req(ModeFlush, '0, 1'b0, '0);
  endtask

  // working set a little larger than the cache: steady eviction churn
  task automatic test_lru_churn();
    logic [TagW-1:0] pool[8];
    foreach (pool[i]) pool[i] = rand_tag();
    repeat (800) begin
      if ($urandom_range(0, 59) == 0)
        send_req(ModeFlush, rand_tag(), 1'($urandom), HandleW'($urandom));
      else
        send_req(ModeLookup, pool[$urandom_range(0, 7)], $urandom_range(0, 9) != 0,
                 HandleW'($urandom));
    end
  endtask

  // working set that fits: mostly hits, reordering of recency
  task automatic test_hot_set();
    logic [TagW-1:0] pool[6];
    foreach (pool[i]) pool[i] = rand_tag();
    repeat (500) begin
      if ($urandom_range(0, 99) == 0)
        send_req(ModeFlush, rand_tag(), 1'($urandom), HandleW'($urandom));
      else
        send_req(ModeLookup, pool[$urandom_range(0, 5)], 1'($urandom_range(0, 1)),
                 HandleW'($urandom));
    end
  endtask

  // fresh keys, failed creates and frequent flushes mixed in
  task automatic test_mixed_noise();
    logic [TagW-1:0] pool[10];
    int              roll;
    foreach (pool[i]) pool[i] = rand_tag();
    repeat (500) begin
      roll = $urandom_range(0, 9);
      if (roll == 0)
        send_req(ModeFlush, rand_tag(), 1'($urandom), HandleW'($urandom));
      else if (roll < 4)
        send_req(ModeLookup, rand_tag(), 1'($urandom), HandleW'($urandom));
      else
        send_req(ModeLookup, pool[$urandom_range(0, 9)], 1'($urandom),
                 HandleW'($urandom));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    err_cnt      = 0;
    mism_cnt     = 0;
    quiet_cycles = 0;
    calm_left    = 0;
    foreach (line_valid[i]) begin
      line_valid[i]  = 1'b0;
      line_tag[i]    = '0;
      line_handle[i] = '0;
      line_rank[i]   = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_lru_churn();
    test_hot_set();
    test_mixed_noise();

    // drain outstanding results, then keep watching for stray ones
    start <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
